### design/kcst_pkg.sv
// ----------------------------------------------------------------------------
// kcst_pkg
// Shared types, widths and constants of the keyed count slot table.
// ----------------------------------------------------------------------------
package kcst_pkg;

	localparam int NUM_OBJECTS_DEF      = 16;
	localparam int SLOTS_PER_OBJECT_DEF = 256;

	localparam int KIND_W   = 1;
	localparam int OBJ_W    = 4;
	localparam int TYPE_W   = 3;
	localparam int KEY_W    = 16;
	localparam int AMT_W    = 16;
	localparam int MOVED_W  = 16;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 32;
	localparam int LIMIT_W  = 8;

	// Slot word: {valid, key, count}
	localparam int ENTRY_W   = 1 + KEY_W + COUNT_W;
	localparam int VALID_BIT = ENTRY_W - 1;

	typedef enum logic [KIND_W-1:0] {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK     = 2'd0,
		STS_BAD    = 2'd1,
		STS_ABSENT = 2'd2,
		STS_FULL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_UPDATE,
		S_RESP
	} state_t;

	// Slot limit per object type; unknown types allow no new keys.
	function automatic logic [LIMIT_W-1:0] type_limit(input logic [TYPE_W-1:0] t);
		logic [LIMIT_W-1:0] lim;
		case (t)
			3'd0:    lim = 8'd192;
			3'd1:    lim = 8'd12;
			3'd2:    lim = 8'd48;
			3'd3:    lim = 8'd96;
			3'd4:    lim = 8'd24;
			3'd5:    lim = 8'd32;
			default: lim = 8'd0;
		endcase
		return lim;
	endfunction

endpackage

### design/kcst_req_if.sv
// ----------------------------------------------------------------------------
// kcst_req_if
// Request channel: one operation word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kcst_req_if
	import kcst_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [OBJ_W-1:0]    object_index;
	logic [TYPE_W-1:0]   object_type;
	logic [KEY_W-1:0]    item_key;
	logic [AMT_W-1:0]    amount;

	modport source (
		output valid, kind, object_index, object_type, item_key, amount,
		input  ready
	);
	modport sink (
		input  valid, kind, object_index, object_type, item_key, amount,
		output ready
	);
endinterface

### design/kcst_rsp_if.sv
// ----------------------------------------------------------------------------
// kcst_rsp_if
// Response channel: one result word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kcst_rsp_if
	import kcst_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [MOVED_W-1:0]  moved;
	logic [STATUS_W-1:0] status;

	modport source (
		output valid, moved, status,
		input  ready
	);
	modport sink (
		input  valid, moved, status,
		output ready
	);
endinterface

### design/keyed_count_slot_table.sv
// ----------------------------------------------------------------------------
// keyed_count_slot_table
// Per-object tables of (key, count) slots with a type-dependent slot limit.
// ----------------------------------------------------------------------------
// Usage:
//   req takes one operation word (insert or extract of amount for item_key
//   in the table of object_index); rsp returns one word (moved, status) for
//   each request, in order.
//   A request with key 0, amount 0 or an object beyond the table set is
//   answered without touching the slot memory.
//   Any other request walks the object's SLOTS_PER_OBJECT slots through the
//   single-port slot memory, one read per cycle, then passes a drain and an
//   update state, which writes back at most one slot, before responding.
//   One request is in flight at a time; req.ready is high only while the
//   block is idle. The next request may be taken while a response still
//   waits in the rsp register; a stalled rsp holds the block in its
//   response state until the register frees.
//   After arst_n the block sweeps all NUM_OBJECTS * SLOTS_PER_OBJECT slots
//   (4096 at defaults) to clear every valid mark; req.ready stays low
//   during the sweep.
// ----------------------------------------------------------------------------
module keyed_count_slot_table
	import kcst_pkg::*;
#(
	parameter int NUM_OBJECTS      = NUM_OBJECTS_DEF,
	parameter int SLOTS_PER_OBJECT = SLOTS_PER_OBJECT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	kcst_req_if.sink   req,
	kcst_rsp_if.source rsp
);

	localparam int DEPTH  = NUM_OBJECTS * SLOTS_PER_OBJECT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IDX_W  = $clog2(SLOTS_PER_OBJECT);
	localparam int USED_W = $clog2(SLOTS_PER_OBJECT + 1);

	state_t state_q, state_d;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic               mem_re, mem_we;
	logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ENTRY_W-1:0] rdata_s1;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;

	logic [ADDR_W-1:0]  clr_q;
	logic [IDX_W-1:0]   scan_q;
	logic [ADDR_W-1:0]  base_q;
	logic [KIND_W-1:0]  kind_q;
	logic [TYPE_W-1:0]  type_q;
	logic [KEY_W-1:0]   key_q;
	logic [AMT_W-1:0]   amt_q;

	logic               found_q, free_q;
	logic [IDX_W-1:0]   hit_idx_q, free_idx_q;
	logic [COUNT_W-1:0] hit_cnt_q;
	logic [USED_W-1:0]  used_q;

	logic [MOVED_W-1:0] res_moved_q;
	status_t            res_status_q;
	logic               out_valid_q;
	logic [MOVED_W-1:0] out_moved_q;
	status_t            out_status_q;

	logic               accept, req_bad, req_range, clr_last, scan_last, out_free;

	logic               upd_we;
	logic [IDX_W-1:0]   upd_idx;
	logic [ENTRY_W-1:0] upd_word;
	logic [MOVED_W-1:0] upd_moved;
	status_t            upd_status;

	assign accept    = req.valid && req.ready;
	assign req_bad   = (req.item_key == '0) || (req.amount == '0);
	assign req_range = 32'(req.object_index) >= 32'(NUM_OBJECTS);
	assign clr_last  = clr_q == ADDR_W'(DEPTH - 1);
	assign scan_last = scan_q == IDX_W'(SLOTS_PER_OBJECT - 1);
	assign out_free  = !out_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) state_d = (req_bad || req_range) ? S_RESP : S_SCAN;
			end
			S_SCAN: begin
				if (scan_last) state_d = S_DRAIN;
			end
			S_DRAIN:  state_d = S_UPDATE;
			S_UPDATE: state_d = S_RESP;
			S_RESP: begin
				if (out_free) state_d = S_IDLE;
			end
			default:  state_d = S_CLEAR;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		req.ready = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		case (state_q)
			S_CLEAR: mem_we = 1'b1;
			S_IDLE:  req.ready = 1'b1;
			S_SCAN:  mem_re = 1'b1;
			S_UPDATE: begin
				mem_we    = upd_we;
				mem_waddr = base_q + ADDR_W'(upd_idx);
				mem_wdata = upd_word;
			end
			default: ;
		endcase
	end

	assign mem_raddr = base_q + ADDR_W'(scan_q);

	// write-back of the found or free slot
	always_comb begin
		logic [COUNT_W-1:0] room, new_cnt;
		logic [AMT_W-1:0]   part;
		room       = ~hit_cnt_q;
		new_cnt    = hit_cnt_q;
		part       = amt_q;
		upd_we     = 1'b0;
		upd_idx    = hit_idx_q;
		upd_word   = '0;
		upd_moved  = '0;
		upd_status = STS_OK;
		if (kind_q == OP_INSERT) begin
			if (found_q) begin
				if (room < COUNT_W'(amt_q)) part = room[AMT_W-1:0];
				new_cnt   = hit_cnt_q + COUNT_W'(part);
				upd_we    = 1'b1;
				upd_word  = {1'b1, key_q, new_cnt};
				upd_moved = part;
			end else if (used_q >= USED_W'(type_limit(type_q)) || !free_q) begin
				upd_status = STS_FULL;
			end else begin
				upd_we    = 1'b1;
				upd_idx   = free_idx_q;
				upd_word  = {1'b1, key_q, COUNT_W'(amt_q)};
				upd_moved = amt_q;
			end
		end else begin
			if (found_q) begin
				if (hit_cnt_q < COUNT_W'(amt_q)) part = hit_cnt_q[AMT_W-1:0];
				new_cnt   = hit_cnt_q - COUNT_W'(part);
				upd_we    = 1'b1;
				upd_word  = {new_cnt != '0, key_q, new_cnt};
				upd_moved = part;
			end else begin
				upd_status = STS_ABSENT;
			end
		end
	end

	// slot memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			scan_q       <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			found_q      <= 1'b0;
			free_q       <= 1'b0;
			used_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= mem_re;
			rd_idx_s1 <= scan_q;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == S_SCAN)  scan_q <= scan_q + 1'b1;
			if (accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
				used_q  <= '0;
			end else if (rd_vld_s1) begin
				if (rdata_s1[VALID_BIT]) begin
					used_q <= used_q + 1'b1;
					if (!found_q && rdata_s1[VALID_BIT-1 -: KEY_W] == key_q) begin
						found_q <= 1'b1;
					end
				end else if (!free_q) begin
					free_q <= 1'b1;
				end
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= req.kind;
			type_q    <= req.object_type;
			key_q     <= req.item_key;
			amt_q     <= req.amount;
			base_q    <= ADDR_W'(req.object_index) * ADDR_W'(SLOTS_PER_OBJECT);
			res_moved_q  <= '0;
			res_status_q <= req_bad ? STS_BAD : STS_ABSENT;
		end
		if (rd_vld_s1) begin
			if (rdata_s1[VALID_BIT]) begin
				if (!found_q && rdata_s1[VALID_BIT-1 -: KEY_W] == key_q) begin
					hit_idx_q <= rd_idx_s1;
					hit_cnt_q <= rdata_s1[COUNT_W-1:0];
				end
			end else if (!free_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
		if (state_q == S_UPDATE) begin
			res_moved_q  <= upd_moved;
			res_status_q <= upd_status;
		end
		if (state_q == S_RESP && out_free) begin
			out_moved_q  <= res_moved_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.moved  = out_moved_q;
	assign rsp.status = out_status_q;

`ifndef SYNTH
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while another is in flight");

	a_fail_moves_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STS_OK) |-> rsp.moved == '0)
		else $error("failed operation reports a nonzero move");

	a_update_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPDATE) |-> ($past(state_q) == S_DRAIN && !mem_re))
		else $error("slot write-back without a completed scan");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for keyed_count_slot_table. A directed table covers
// reset state, bad words, unknown types, drain to zero and a table filled to
// its type limit. It is followed by random traffic on a few hot objects with
// small key pools, so that hits, frees and full tables recur. Every accepted
// request is run through a local slot table model. Responses are compared in
// order, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
	import kcst_pkg::*;

	localparam int N_OBJ       = NUM_OBJECTS_DEF;
	localparam int N_SLOT      = SLOTS_PER_OBJECT_DEF;
	localparam int N_RANDOM    = 400;
	localparam int IDLE_LIMIT  = 20000;
	localparam int TAIL_CYCLES = 300;
	localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
	localparam int unsigned TYPE_CAP [8] = '{192, 12, 48, 96, 24, 32, 0, 0};

	typedef struct {
		op_t               kind;
		logic [OBJ_W-1:0]  obj;
		logic [TYPE_W-1:0] typ;
		logic [KEY_W-1:0]  key;
		logic [AMT_W-1:0]  amt;
	} op_word_t;

	typedef struct {
		logic [MOVED_W-1:0] moved;
		status_t            status;
	} rsp_word_t;

	typedef struct {
		op_word_t  w;
		bit        known;
		rsp_word_t r;
	} vec_t;

	logic clk;
	logic arst_n;

	kcst_req_if req ();
	kcst_rsp_if rsp ();

	keyed_count_slot_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	logic [KEY_W-1:0]   tbl_key   [N_OBJ][N_SLOT];
	logic [COUNT_W-1:0] tbl_count [N_OBJ][N_SLOT];
	bit                 tbl_used  [N_OBJ][N_SLOT];

	rsp_word_t         pending_rsp [$];
	vec_t              vectors [$];
	logic [TYPE_W-1:0] home_type [N_OBJ];
	rsp_word_t         head_rsp;
	int                errors = 0;
	int                idle_cycles = 0;
	bit                calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic rsp_word_t apply_op(op_word_t w);
		rsp_word_t r;
		int used;
		int lim;
		int hit;
		int spare;
		logic [COUNT_W-1:0] room;
		logic [COUNT_W-1:0] step;
		r.moved = '0;
		used = 0;
		hit = -1;
		spare = -1;
		if (w.key == '0 || w.amt == '0) begin
			r.status = STS_BAD;
			return r;
		end
		for (int i = 0; i < N_SLOT; i++) begin
			if (tbl_used[w.obj][i]) begin
				used++;
				if (hit < 0 && tbl_key[w.obj][i] == w.key)
					hit = i;
			end else if (spare < 0) begin
				spare = i;
			end
		end
		r.status = STS_OK;
		if (w.kind == OP_INSERT) begin
			if (hit >= 0) begin
				room = COUNT_TOP - tbl_count[w.obj][hit];
				step = (COUNT_W'(w.amt) < room) ? COUNT_W'(w.amt) : room;
				tbl_count[w.obj][hit] += step;
				r.moved = step[MOVED_W-1:0];
			end else begin
				lim = TYPE_CAP[w.typ];
				if (lim > N_SLOT)
					lim = N_SLOT;
				if (used >= lim || spare < 0) begin
					r.status = STS_FULL;
				end else begin
					tbl_used[w.obj][spare] = 1'b1;
					tbl_key[w.obj][spare] = w.key;
					tbl_count[w.obj][spare] = COUNT_W'(w.amt);
					r.moved = w.amt;
				end
			end
		end else if (hit < 0) begin
			r.status = STS_ABSENT;
		end else begin
			step = (COUNT_W'(w.amt) < tbl_count[w.obj][hit]) ?
				COUNT_W'(w.amt) : tbl_count[w.obj][hit];
			tbl_count[w.obj][hit] -= step;
			if (tbl_count[w.obj][hit] == '0)
				tbl_used[w.obj][hit] = 1'b0;
			r.moved = step[MOVED_W-1:0];
		end
		return r;
	endfunction

	function automatic int draw_gap();
		return calm ? 0 : int'($urandom_range(0, 4));
	endfunction

	// hot objects 0..3 with a small key pool so tables fill and drain
	function automatic op_word_t random_word();
		op_word_t w;
		int pick;
		w.kind = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_EXTRACT;
		w.obj = ($urandom_range(0, 99) < 70) ? OBJ_W'($urandom_range(0, 3)) :
			OBJ_W'($urandom_range(0, N_OBJ - 1));
		w.typ = ($urandom_range(0, 9) == 0) ? TYPE_W'($urandom_range(0, 7)) :
			home_type[w.obj];
		pick = $urandom_range(0, 99);
		if (pick < 80)
			w.key = KEY_W'($urandom_range(1, 30));
		else if (pick < 95)
			w.key = KEY_W'($urandom_range(1, 65535));
		else
			w.key = '1;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			w.amt = AMT_W'($urandom_range(1, 16));
		else if (pick < 90)
			w.amt = AMT_W'($urandom_range(1, 65535));
		else
			w.amt = '1;
		pick = $urandom_range(0, 99);
		if (pick < 2) begin
			w.key = '0;
		end else if (pick < 4) begin
			w.amt = '0;
		end else if (pick < 5) begin
			w.key = '0;
			w.amt = '0;
		end
		return w;
	endfunction

	task automatic add_vec(op_t k, int obj, int typ, int key, int amt,
			bit known, int mv, status_t st);
		vec_t v;
		v.w.kind = k;
		v.w.obj = OBJ_W'(obj);
		v.w.typ = TYPE_W'(typ);
		v.w.key = KEY_W'(key);
		v.w.amt = AMT_W'(amt);
		v.known = known;
		v.r.moved = MOVED_W'(mv);
		v.r.status = st;
		vectors.insert(vectors.size(), v);
	endtask

	task automatic idle_gap();
		int n;
		n = draw_gap();
		if (n > 0) begin
			req.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drive_word(op_word_t w, bit known, rsp_word_t r);
		rsp_word_t p;
		req.valid <= 1'b1;
		req.kind <= w.kind;
		req.object_index <= w.obj;
		req.object_type <= w.typ;
		req.item_key <= w.key;
		req.amount <= w.amt;
		do @(posedge clk); while (!(req.valid && req.ready));
		p = apply_op(w);
		if (known)
			p = r;
		pending_rsp.insert(pending_rsp.size(), p);
	endtask

	initial begin
		op_word_t w;
		rsp_word_t none;
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.kind <= OP_INSERT;
		req.object_index <= '0;
		req.object_type <= '0;
		req.item_key <= '0;
		req.amount <= '0;
		none.moved = '0;
		none.status = STS_OK;
		foreach (tbl_used[i, j])
			tbl_used[i][j] = 1'b0;
		foreach (home_type[i])
			home_type[i] = TYPE_W'($urandom_range(0, 5));
		home_type[0] = 3'd1;
		home_type[1] = 3'd4;

		add_vec(OP_EXTRACT, 0, 0, 1, 5, 1, 0, STS_ABSENT);
		add_vec(OP_INSERT, 0, 0, 0, 5, 1, 0, STS_BAD);
		add_vec(OP_INSERT, 0, 0, 1, 0, 1, 0, STS_BAD);
		add_vec(OP_EXTRACT, 15, 7, 0, 0, 1, 0, STS_BAD);
		// unknown type: no new key
		add_vec(OP_INSERT, 15, 6, 'hFFFF, 'hFFFF, 1, 0, STS_FULL);
		add_vec(OP_INSERT, 15, 0, 'hFFFF, 'hFFFF, 1, 'hFFFF, STS_OK);
		// unknown type: present key still adds
		add_vec(OP_INSERT, 15, 7, 'hFFFF, 1, 0, 0, STS_OK);
		add_vec(OP_EXTRACT, 15, 7, 'hFFFF, 1, 0, 0, STS_OK);
		add_vec(OP_EXTRACT, 15, 0, 'hFFFF, 'hFFFF, 0, 0, STS_OK);
		add_vec(OP_EXTRACT, 15, 0, 'hFFFF, 1, 1, 0, STS_ABSENT);
		for (int k = 1; k <= 12; k++)
			add_vec(OP_INSERT, 5, 1, k, k * 'h1111, 0, 0, STS_OK);
		add_vec(OP_INSERT, 5, 1, 13, 7, 1, 0, STS_FULL);
		add_vec(OP_INSERT, 5, 3, 13, 7, 0, 0, STS_OK);
		add_vec(OP_EXTRACT, 5, 1, 1, 'hFFFF, 0, 0, STS_OK);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (vectors[i]) begin
			idle_gap();
			drive_word(vectors[i].w, vectors[i].known, vectors[i].r);
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			calm = ((i / 50) % 4) == 3;
			if (i == N_RANDOM / 2 || $urandom_range(0, 49) == 0) begin
				req.valid <= 1'b0;
				do @(posedge clk); while (pending_rsp.size() != 0);
			end else begin
				idle_gap();
			end
			w = random_word();
			drive_word(w, 1'b0, none);
		end
		req.valid <= 1'b0;
		calm = 1'b0;

		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS keyed_count_slot_table");
		else
			$display("FAIL keyed_count_slot_table");
		$finish;
	end

	initial begin
		int n;
		rsp.ready <= 1'b0;
		@(posedge clk);
		forever begin
			n = draw_gap();
			if (n > 0) begin
				rsp.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!(rsp.valid && rsp.ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected word moved=%h status=%0d",
					$time, rsp.moved, rsp.status);
				errors++;
			end else begin
				head_rsp = pending_rsp.pop_front();
				if (rsp.moved !== head_rsp.moved) begin
					$display("%0t: moved expected %h, got %h",
						$time, head_rsp.moved, rsp.moved);
					errors++;
				end
				if (rsp.status !== head_rsp.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, head_rsp.status, rsp.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("FAIL keyed_count_slot_table");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

### keyed_count_slot_table.f
design/kcst_pkg.sv
design/kcst_req_if.sv
design/kcst_rsp_if.sv
design/keyed_count_slot_table.sv
sim/tb.sv
